[sv/cfb_pkg.sv]
// Shared types and constants of the checksummed frame builder.
package cfb_pkg;

    typedef logic [7:0] t_byte;

    localparam int        RUN_MAX     = 7;                      // most bytes one item can cause
    localparam int        RUN_CNT_W   = $clog2(RUN_MAX + 1);
    localparam int        CNT_W       = 7;                      // sample count width
    localparam int        ADDR_W      = 3;                      // APB byte address width
    localparam int        DATA_W      = 32;
    localparam t_byte     HEADER_BYTE = 8'h5A;
    localparam logic [CNT_W-1:0] MAX_SAMPLES = 7'd127;

    // Register index on paddr[ADDR_W-1].
    localparam logic      REG_WIDE    = 1'b0;

    typedef struct packed {
        t_byte [RUN_MAX-1:0]  bytes;
        logic  [RUN_MAX-1:0]  chk;
        logic  [RUN_CNT_W-1:0] cnt;
    } t_run;

endpackage

[sv/cfb_if.sv]
// Stream interfaces of the frame builder: sample input and byte output.
interface cfb_in_if;
    logic                 valid;
    logic                 ready;
    logic                 start_frame;
    cfb_pkg::t_byte       frame_code;
    logic [6:0]           sample_count;
    logic [15:0]          sample;

    modport source (output valid, start_frame, frame_code, sample_count, sample,
                    input ready);
    modport sink   (input valid, start_frame, frame_code, sample_count, sample,
                    output ready);
endinterface

interface cfb_out_if;
    logic                 valid;
    logic                 ready;
    cfb_pkg::t_byte       tx_byte;
    logic                 last_of_run;
    logic                 is_checksum;

    modport source (output valid, tx_byte, last_of_run, is_checksum, input ready);
    modport sink   (input valid, tx_byte, last_of_run, is_checksum, output ready);
endinterface

[sv/cfb_apb_regs.sv]
// APB configuration register file of the frame builder.
module cfb_apb_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_psel,
    input  logic                         i_penable,
    input  logic                         i_pwrite,
    input  logic [cfb_pkg::ADDR_W-1:0]   i_paddr,
    input  logic [cfb_pkg::DATA_W-1:0]   i_pwdata,
    output logic [cfb_pkg::DATA_W-1:0]   o_prdata,
    output logic                         o_pready,
    output logic                         o_wide
);
    import cfb_pkg::*;

    logic r_wide;
    logic n_wide;
    logic wr_en;
    logic sel_wide;

    assign sel_wide = (i_paddr[ADDR_W-1] == REG_WIDE);
    assign wr_en    = i_psel && i_penable && i_pwrite && o_pready;
    assign o_pready = 1'b1;

    always_comb begin
        n_wide = r_wide;
        if (wr_en && sel_wide) begin
            n_wide = i_pwdata[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wide <= 1'b1;
        end else begin
            r_wide <= n_wide;
        end
    end

    assign o_prdata = sel_wide ? {{(DATA_W-1){1'b0}}, r_wide} : '0;
    assign o_wide   = r_wide;

endmodule

[sv/cfb_encoder.sv]
// Frame state and the byte run that one accepted item produces.
module cfb_encoder (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic                         i_cfg_wide,
    input  logic                         i_start,
    input  cfb_pkg::t_byte               i_code,
    input  logic [cfb_pkg::CNT_W-1:0]    i_count,
    input  logic [15:0]                  i_sample,
    output cfb_pkg::t_run                o_run
);
    import cfb_pkg::*;

    t_byte            r_sum,  n_sum;
    logic [CNT_W-1:0] r_left, n_left;
    logic             r_open, n_open;
    logic             r_wide, n_wide;

    logic             wide;
    logic [CNT_W-1:0] cnt, left, left2;
    t_byte            len, sum_h, base, hi, lo, sum2;
    t_byte            p [3];
    logic [2:0]       pc;
    logic [1:0]       pn;
    logic             close;

    always_comb begin
        wide  = i_start ? i_cfg_wide : r_wide;
        cnt   = (i_count > MAX_SAMPLES) ? MAX_SAMPLES : i_count;
        len   = wide ? {cnt, 1'b0} : {1'b0, cnt};
        sum_h = HEADER_BYTE + HEADER_BYTE + i_code + len;
        base  = i_start ? sum_h : r_sum;
        left  = i_start ? cnt : r_left;
        hi    = i_sample[15:8];
        lo    = i_sample[7:0];
        sum2  = base + (wide ? hi : 8'd0) + lo;
        left2 = left - 7'd1;
        close = (left2 == '0);

        // Payload bytes of one sample, with the checksum when it ends the frame.
        p[0] = lo;
        p[1] = '0;
        p[2] = '0;
        pc   = '0;
        pn   = 2'd1;
        if (wide) begin
            p[0] = hi;
            p[1] = lo;
            pn   = 2'd2;
            if (close) begin
                p[2]  = sum2;
                pc[2] = 1'b1;
                pn    = 2'd3;
            end
        end else if (close) begin
            p[1]  = sum2;
            pc[1] = 1'b1;
            pn    = 2'd2;
        end

        o_run  = '0;
        n_sum  = r_sum;
        n_left = r_left;
        n_open = r_open;
        n_wide = r_wide;
        if (i_start) begin
            n_wide       = i_cfg_wide;
            o_run.bytes[0] = HEADER_BYTE;
            o_run.bytes[1] = HEADER_BYTE;
            o_run.bytes[2] = i_code;
            o_run.bytes[3] = len;
            if (cnt == '0) begin
                o_run.bytes[4] = sum_h;
                o_run.chk[4]   = 1'b1;
                o_run.cnt      = RUN_CNT_W'(5);
                n_open         = 1'b0;
                n_left         = '0;
                n_sum          = '0;
            end else begin
                for (int i = 0; i < 3; i++) begin
                    o_run.bytes[4+i] = p[i];
                    o_run.chk[4+i]   = pc[i];
                end
                o_run.cnt = RUN_CNT_W'(4) + RUN_CNT_W'(pn);
                n_left    = left2;
                n_open    = !close;
                n_sum     = close ? 8'd0 : sum2;
            end
        end else if (r_open) begin
            for (int i = 0; i < 3; i++) begin
                o_run.bytes[i] = p[i];
                o_run.chk[i]   = pc[i];
            end
            o_run.cnt = RUN_CNT_W'(pn);
            n_left    = left2;
            n_open    = !close;
            n_sum     = close ? 8'd0 : sum2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_left <= '0;
            r_open <= 1'b0;
            r_wide <= 1'b1;
        end else if (i_accept) begin
            r_sum  <= n_sum;
            r_left <= n_left;
            r_open <= n_open;
            r_wide <= n_wide;
        end
    end

    a_open_has_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open |-> (r_left != '0))
        else $error("open frame with no samples left");

    a_closed_sum_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_open |-> (r_sum == '0))
        else $error("running sum not cleared outside a frame");

    a_start_has_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_start) |-> (o_run.cnt >= RUN_CNT_W'(5)))
        else $error("start item produced a short run");

endmodule

[sv/cfb_serializer.sv]
// Run buffer that hands the bytes of one item out one per transfer.
module cfb_serializer (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  cfb_pkg::t_run  i_run,
    output logic           o_can_load,
    cfb_out_if.source      o_out
);
    import cfb_pkg::*;

    t_byte                r_bytes [RUN_MAX];
    t_byte                n_bytes [RUN_MAX];
    logic [RUN_MAX-1:0]   r_chk,  n_chk;
    logic [RUN_CNT_W-1:0] r_cnt,  n_cnt;
    logic                 xfer;

    assign xfer       = o_out.valid && o_out.ready;
    assign o_can_load = (r_cnt == '0) || ((r_cnt == RUN_CNT_W'(1)) && o_out.ready);

    always_comb begin
        n_bytes = r_bytes;
        n_chk   = r_chk;
        n_cnt   = r_cnt;
        if (i_load) begin
            for (int i = 0; i < RUN_MAX; i++) begin
                n_bytes[i] = i_run.bytes[i];
            end
            n_chk = i_run.chk;
            n_cnt = i_run.cnt;
        end else if (xfer) begin
            for (int i = 0; i < RUN_MAX - 1; i++) begin
                n_bytes[i] = r_bytes[i+1];
            end
            n_chk = {1'b0, r_chk[RUN_MAX-1:1]};
            n_cnt = r_cnt - RUN_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_bytes <= n_bytes;
        r_chk   <= n_chk;
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    assign o_out.valid       = (r_cnt != '0);
    assign o_out.tx_byte     = r_bytes[0];
    assign o_out.last_of_run = (r_cnt == RUN_CNT_W'(1));
    assign o_out.is_checksum = r_chk[0];

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> ((r_cnt == '0) || ((r_cnt == RUN_CNT_W'(1)) && xfer)))
        else $error("run loaded over bytes still pending");

    a_cnt_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= RUN_CNT_W'(RUN_MAX))
        else $error("run count out of range");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_load && (i_run.cnt != '0)) |=> (o_out.valid && (r_cnt == $past(i_run.cnt))))
        else $error("loaded run not presented");

endmodule

[sv/checksummed_frame_builder_core.sv]
// Top level of the checksummed frame builder: samples in, framed bytes out.
//
// Usage: items arrive on i_in (valid/ready). An item with start_frame set
// opens a frame and causes the header 0x5A 0x5A, frame_code and the length
// byte, then its own sample as first payload (or the checksum at once when
// sample_count is zero). Later items each carry one sample: two bytes, high
// first, in 16-bit mode, one byte in 8-bit mode. The last sample of a frame
// is followed by the checksum byte, the 8-bit sum of all earlier frame bytes.
// Items outside an open frame are dropped without output.
// Bytes leave on o_out, one per transfer, with last_of_run on the final byte
// of an item and is_checksum on the checksum byte.
// The first byte of an item is valid in the cycle after its transfer.
// Bytes go out one per cycle through the output run buffer while the receiver
// is ready: an item causes two bytes per 16-bit sample, one per 8-bit sample,
// one more when the sample closes the frame, and up to seven for a start
// item. A dropped item causes no byte but is still taken like any other.
// A new item is taken in the cycle the previous item's last byte
// transfers.
// When the receiver stalls, the pending byte holds and input ready falls.
// Reset (synchronous, active low) closes any frame, empties the output run
// and sets wide_samples to 1. The mode is latched per frame; the user must
// write the APB register at address 0 only while idle (not enforced).
module checksummed_frame_builder_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    cfb_in_if.sink                       i_in,
    cfb_out_if.source                    o_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [cfb_pkg::ADDR_W-1:0]   paddr,
    input  logic [cfb_pkg::DATA_W-1:0]   pwdata,
    output logic [cfb_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);
    import cfb_pkg::*;

    logic  cfg_wide;
    logic  can_load;
    logic  accept;
    t_run  run;

    // Configuration register.
    cfb_apb_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_wide    (cfg_wide)
    );

    // An item is taken whenever the run buffer is empty or is handing out its
    // last byte in this cycle, so items follow each other without a gap.
    assign i_in.ready = can_load;
    assign accept     = i_in.valid && can_load;

    // Frame state and the byte run of the item on the input channel.
    cfb_encoder u_enc (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_cfg_wide (cfg_wide),
        .i_start    (i_in.start_frame),
        .i_code     (i_in.frame_code),
        .i_count    (i_in.sample_count),
        .i_sample   (i_in.sample),
        .o_run      (run)
    );

    // Output run buffer, one byte per transfer.
    cfb_serializer u_ser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (accept),
        .i_run      (run),
        .o_can_load (can_load),
        .o_out      (o_out)
    );

endmodule

[tb/tx_byte_checker.sv]
// Watches the sample and byte channels and the register port, predicts every byte and compares.
module tx_byte_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    cfb_in_if                           in_mon,
    cfb_out_if                          out_mon,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cfb_pkg::ADDR_W-1:0]  paddr,
    input  logic [cfb_pkg::DATA_W-1:0]  pwdata,
    input  logic [cfb_pkg::DATA_W-1:0]  prdata,
    input  logic                        pready,
    output int                          o_fail_cnt,
    output int                          o_pending
);
    import cfb_pkg::*;

    localparam int PRINT_CAP = 100;

    typedef struct packed {
        t_byte data;
        logic  last;
        logic  chk;
    } t_due_byte;

    t_due_byte        tx_due_q[$];

    // Own copy of the register and of the framing state.
    logic             wide_cfg;
    logic             frame_wide_r;
    logic             open_flag;
    t_byte            sum_acc;
    logic [CNT_W-1:0] left_cnt;

    initial begin
        o_fail_cnt = 0;
        o_pending  = 0;
    end

    // Lines stop after a cap so a badly broken block cannot flood the log.
    task automatic report(input string what);
        o_fail_cnt++;
        if (o_fail_cnt <= PRINT_CAP) begin
            $display("ERROR at %0t: %s", $time, what);
        end
    endtask

    task automatic push_frame_byte(input t_byte b, input logic chk);
        tx_due_q.push_back('{data: b, last: 1'b0, chk: chk});
        if (!chk) begin
            sum_acc = sum_acc + b;
        end
    endtask

    // One sample: high byte first in wide frames, then the low byte, and the
    // checksum once the last sample of the frame has gone out.
    task automatic push_sample(input logic [15:0] s);
        if (frame_wide_r) begin
            push_frame_byte(s[15:8], 1'b0);
        end
        push_frame_byte(s[7:0], 1'b0);
        left_cnt = left_cnt - 1'b1;
        if (left_cnt == '0) begin
            push_frame_byte(sum_acc, 1'b1);
            open_flag = 1'b0;
            sum_acc   = '0;
        end
    endtask

    task automatic encode_item(input logic st, input t_byte code,
                               input logic [CNT_W-1:0] cnt, input logic [15:0] s);
        int        first;
        logic [CNT_W-1:0] n;
        t_due_byte tail;
        first = tx_due_q.size();
        n     = (cnt > MAX_SAMPLES) ? MAX_SAMPLES : cnt;
        if (st) begin
            // A start abandons any open frame without a checksum.
            frame_wide_r = wide_cfg;
            sum_acc      = '0;
            left_cnt     = n;
            push_frame_byte(HEADER_BYTE, 1'b0);
            push_frame_byte(HEADER_BYTE, 1'b0);
            push_frame_byte(code, 1'b0);
            push_frame_byte(frame_wide_r ? t_byte'({n, 1'b0}) : t_byte'(n), 1'b0);
            if (n == '0) begin
                // Empty frame: the checksum follows the header and the sample is unused.
                push_frame_byte(sum_acc, 1'b1);
                open_flag = 1'b0;
                sum_acc   = '0;
            end else begin
                open_flag = 1'b1;
                push_sample(s);
            end
        end else if (open_flag) begin
            push_sample(s);
        end
        if (tx_due_q.size() > first) begin
            tail      = tx_due_q.pop_back();
            tail.last = 1'b1;
            tx_due_q.push_back(tail);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_due_byte want;
        logic [cfb_pkg::DATA_W-1:0] rd_want;
        if (!i_rst_n) begin
            tx_due_q.delete();
            wide_cfg     = 1'b1;
            frame_wide_r = 1'b1;
            open_flag    = 1'b0;
            sum_acc      = '0;
            left_cnt     = '0;
        end else begin
            // Output first, so a byte never matches an item taken at the same edge.
            if (out_mon.valid && out_mon.ready) begin
                if (tx_due_q.size() == 0) begin
                    report($sformatf("byte %02h with nothing expected", out_mon.tx_byte));
                end else begin
                    want = tx_due_q.pop_front();
                    if (out_mon.tx_byte !== want.data) begin
                        report($sformatf("tx_byte %02h, expected %02h",
                                         out_mon.tx_byte, want.data));
                    end
                    if (out_mon.last_of_run !== want.last) begin
                        report($sformatf("last_of_run %b, expected %b on byte %02h",
                                         out_mon.last_of_run, want.last, want.data));
                    end
                    if (out_mon.is_checksum !== want.chk) begin
                        report($sformatf("is_checksum %b, expected %b on byte %02h",
                                         out_mon.is_checksum, want.chk, want.data));
                    end
                end
            end
            // An item taken at the edge of a register write still sees the old mode.
            if (in_mon.valid && in_mon.ready) begin
                encode_item(in_mon.start_frame, in_mon.frame_code,
                            in_mon.sample_count, in_mon.sample);
            end
            if (psel && penable && pready) begin
                if (pwrite) begin
                    if (paddr[ADDR_W-1] == REG_WIDE) begin
                        wide_cfg = pwdata[0];
                    end
                end else if (paddr[ADDR_W-1] == REG_WIDE) begin
                    rd_want = {{(DATA_W-1){1'b0}}, wide_cfg};
                    if (prdata !== rd_want) begin
                        report($sformatf("wide_samples read %h, expected %h", prdata, rd_want));
                    end
                end
            end
        end
        o_pending = tx_due_q.size();
    end

endmodule

[tb/testbench.sv]
// Top of the frame builder testbench: clock, reset, stimulus, receiver stalls and verdict.
module testbench;
    import cfb_pkg::*;

    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 11;
    localparam int RANDOM_ITEMS = 208;
    // Cycles to let pass after the last expected byte before touching the
    // register; the first byte of an item shows in the cycle after its transfer.
    localparam int SETTLE       = 4;
    // Cycles without any transfer before the run is declared hung. The
    // longest correct quiet stretch is a sender gap plus a receiver stall.
    localparam int IDLE_LIMIT   = 1000;
    localparam int TAIL_CYCLES  = 10;

    localparam logic [ADDR_W-1:0] WIDE_ADDR = {REG_WIDE, {(ADDR_W-1){1'b0}}};

    typedef enum logic [1:0] {RX_FREE, RX_RANDOM, RX_PERIODIC} t_rx_mode;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    int                 fail_cnt;
    int                 pending;
    int                 idle_cycles;

    // Stimulus bookkeeping.
    int                 burst_left;
    int                 items_sent;
    logic               gen_open;
    int                 pick;
    int                 cnt;
    int                 more;
    int                 k;
    logic               cut;
    logic               open_after;

    // Receiver stall pattern.
    t_rx_mode           rx_mode;
    int                 rx_window;
    int                 rx_phase;

    cfb_in_if  in_if ();
    cfb_out_if out_if ();

    checksummed_frame_builder_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    tx_byte_checker u_chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .in_mon     (in_if),
        .out_mon    (out_if),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_fail_cnt (fail_cnt),
        .o_pending  (pending)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // The watchdog restarts on every transfer of any channel, the register
    // port included, so only a real hang runs it out.
    initial idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
            (psel && penable && pready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles == IDLE_LIMIT) begin
            $display("FAIL checksummed_frame_builder_core");
            $finish;
        end
    end

    // The receiver switches between free running, random stalls and a fixed
    // stall pattern, each for a window of random length, so stalls land on
    // header, payload and checksum bytes alike.
    initial begin
        out_if.ready = 1'b0;
        rx_window    = 0;
        rx_phase     = 0;
        forever begin
            @(negedge i_clk);
            if (rx_window == 0) begin
                rx_mode   = t_rx_mode'($urandom_range(0, 2));
                rx_window = $urandom_range(20, 80);
            end
            rx_window--;
            rx_phase++;
            case (rx_mode)
                RX_FREE: begin
                    out_if.ready = 1'b1;
                end
                RX_RANDOM: begin
                    out_if.ready = ($urandom_range(0, 2) != 0);
                end
                default: begin
                    out_if.ready = ((rx_phase % 7) > 2);
                end
            endcase
        end
    end

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    // Offers one item and holds it until the transfer. Items come in bursts;
    // when a burst runs out the sender goes quiet for a random gap first.
    // Called and left at a falling edge.
    task automatic send_item(input logic st, input t_byte code,
                             input logic [CNT_W-1:0] n, input logic [15:0] s);
        int gap;
        if (burst_left == 0) begin
            in_if.valid = 1'b0;
            gap = $urandom_range(1, 10);
            repeat (gap) @(negedge i_clk);
            // Now and then a long burst, so the block also runs flat out.
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                    : $urandom_range(1, 8);
        end
        burst_left--;
        in_if.valid        = 1'b1;
        in_if.start_frame  = st;
        in_if.frame_code   = code;
        in_if.sample_count = n;
        in_if.sample       = s;
        do @(posedge i_clk); while (!in_if.ready);
        @(negedge i_clk);
    endtask

    // Stops offering items until every expected byte has arrived, then lets
    // the block settle. Register accesses only follow this.
    task automatic wait_drained();
        in_if.valid = 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // One register access: a setup phase, then the access phase that ends
    // at the edge where pready is high. A read is checked by the checker.
    task automatic reg_access(input logic wr, input logic [DATA_W-1:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = WIDE_ADDR;
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    initial begin
        i_rst_n            = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        in_if.valid        = 1'b0;
        in_if.start_frame  = 1'b0;
        in_if.frame_code   = '0;
        in_if.sample_count = '0;
        in_if.sample       = '0;
        burst_left         = 0;
        items_sent         = 0;
        gen_open           = 1'b0;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // ---- Directed part, 16-bit mode from reset ----
        reg_access(1'b0, '0);                              // reset value of the mode
        send_item(1'b0, 8'h77, 7'd5, 16'hFFFF);            // sample with no frame open
        send_item(1'b1, 8'h00, 7'd0, 16'hABCD);            // empty frame
        send_item(1'b1, 8'hFF, 7'd1, 16'hFFFF);            // single sample, seven bytes
        send_item(1'b1, 8'h12, 7'd3, 16'h0000);
        send_item(1'b0, 8'h00, 7'd0, 16'h8001);
        send_item(1'b1, 8'h34, 7'd2, 16'h1234);            // start inside an open frame
        send_item(1'b0, 8'h00, 7'd0, 16'hFEDC);            // closes the new frame
        send_item(1'b1, 8'hA5, 7'd127, 16'h5A5A);          // largest count, length 254
        send_item(1'b0, 8'h00, 7'd0, 16'h7FFF);

        // Mode change while a frame is open: the open frame stays 16-bit.
        wait_drained();
        reg_access(1'b1, 32'd0);
        reg_access(1'b0, '0);
        send_item(1'b0, 8'h00, 7'd0, 16'h0102);
        send_item(1'b0, 8'h00, 7'd0, 16'hF00F);

        // ---- 8-bit frames ----
        send_item(1'b1, 8'h80, 7'd127, 16'h00FF);          // largest count, length 127
        send_item(1'b1, 8'hC3, 7'd2, 16'hFF00);
        send_item(1'b0, 8'h00, 7'd0, 16'h7F7F);
        send_item(1'b0, 8'hFF, 7'd127, 16'h0000);          // dropped again
        send_item(1'b1, 8'h5A, 7'd0, 16'h0000);            // empty 8-bit frame
        send_item(1'b1, 8'h01, 7'd64, 16'h3C3C);

        // And back: the open 8-bit frame keeps one byte per sample.
        wait_drained();
        reg_access(1'b1, 32'd1);
        send_item(1'b0, 8'h00, 7'd0, 16'h1111);
        send_item(1'b1, 8'h7E, 7'd1, 16'h8000);

        // ---- Random part ----
        // Mostly well-formed frames with random content and small counts; some
        // large counts that get cut short by the next start, some strays
        // outside any frame, and pauses with register traffic between them.
        while (items_sent < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 6 && !gen_open) begin
                send_item(1'b0, t_byte'($urandom), CNT_W'($urandom), rand_sample());
            end else if (pick < 12) begin
                wait_drained();
                if ($urandom_range(0, 1) == 1) begin
                    reg_access(1'b1, DATA_W'($urandom_range(0, 1)));
                end
                reg_access(1'b0, '0);
            end else begin
                case ($urandom_range(0, 9))
                    0:       cnt = 0;
                    1:       cnt = $urandom_range(0, 127);
                    default: cnt = $urandom_range(1, 6);
                endcase
                more = (cnt == 0) ? 0 : cnt - 1;
                cut  = (cnt > 12) || ($urandom_range(0, 9) == 0);
                if (cut && more > 0) begin
                    more = $urandom_range(0, (more > 5) ? 5 : more - 1);
                end
                open_after = (cnt != 0) && (more < cnt - 1);
                send_item(1'b1, t_byte'($urandom), CNT_W'(cnt), rand_sample());
                items_sent++;
                for (k = 0; k < more; k++) begin
                    // Occasionally write a random mode in the middle of a frame.
                    if ($urandom_range(0, 19) == 0) begin
                        wait_drained();
                        reg_access(1'b1, DATA_W'($urandom_range(0, 1)));
                    end
                    send_item(1'b0, t_byte'($urandom), CNT_W'($urandom), rand_sample());
                    items_sent++;
                end
                gen_open = open_after;
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (fail_cnt == 0 && pending == 0) begin
            $display("PASS checksummed_frame_builder_core");
        end else begin
            $display("FAIL checksummed_frame_builder_core");
        end
        $finish;
    end

endmodule

[files.f]
sv/cfb_pkg.sv
sv/cfb_if.sv
sv/cfb_apb_regs.sv
sv/cfb_encoder.sv
sv/cfb_serializer.sv
sv/checksummed_frame_builder_core.sv
tb/tx_byte_checker.sv
tb/testbench.sv
